@@ src/fa_pkg.sv @@
`timescale 1ns / 1ps
// Types and constants shared by the fraction approximator modules.
package fa_pkg;

   localparam int REL_WIDTH = 16;
   localparam logic [REL_WIDTH-1:0] TOL_DEFAULT = 16'd66;
   localparam int TOL_EXTRA = 16;
   localparam int NUM_WIDTH = 34;
   localparam int DEN_WIDTH = 17;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL,
      S_SAT,
      S_CLASS,
      S_SEARCH,
      S_TMUL,
      S_TSUM,
      S_DONE
   } fa_state_type;

   typedef enum logic [1:0] {
      SRCH_IDLE,
      SRCH_MED,
      SRCH_CMP
   } fa_srch_state_type;

   typedef struct packed {
      logic start;
   } fa_srch_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } fa_srch_stat_type;

endpackage

@@ src/fa_mediant.sv @@
`timescale 1ns / 1ps
// Stern-Brocot mediant search unit: one add step and one compare step per mediant.
module fa_mediant #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  fa_pkg::fa_srch_ctl_type                 ctl,
   input  logic [FRAC_BITS+fa_pkg::TOL_EXTRA+1:0]  a_in,
   input  logic [FRAC_BITS+fa_pkg::TOL_EXTRA+1:0]  b_in,
   output fa_pkg::fa_srch_stat_type                stat,
   output logic [FRAC_BITS+1:0]                    num,
   output logic [FRAC_BITS+1:0]                    den
);

   localparam int E  = FRAC_BITS + fa_pkg::TOL_EXTRA;
   localparam int AW = E + 2;
   localparam int MW = FRAC_BITS + 2;
   localparam int PW = MW + AW;
   localparam logic [MW-1:0] LAST_STEP = {2'b01, {FRAC_BITS{1'b0}}};

   fa_pkg::fa_srch_state_type state_ff, state_in;

   logic [MW-1:0] ln_ff, ld_ff, un_ff, ud_ff;
   logic [MW-1:0] mn_ff, md_ff;
   logic [MW-1:0] step_ff;
   logic [PW-1:0] pla_ff, pua_ff, qlb_ff, qub_ff;
   logic [PW-1:0] ma_ff, mb_ff;

   logic [PW-1:0] mn_shift;
   logic          go_up;
   logic          go_dn;
   logic          finish;

   assign mn_shift = PW'({mn_ff, {E{1'b0}}});
   // mediant above the upper bound of the window: it becomes the new upper end
   assign go_up    = ma_ff < mn_shift;
   assign go_dn    = mn_shift < mb_ff;
   assign finish   = !(go_up || go_dn) || (step_ff == LAST_STEP);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fa_pkg::SRCH_IDLE: begin
            if (ctl.start) begin
               state_in = fa_pkg::SRCH_MED;
            end
         end
         fa_pkg::SRCH_MED: begin
            state_in = fa_pkg::SRCH_CMP;
         end
         fa_pkg::SRCH_CMP: begin
            state_in = finish ? fa_pkg::SRCH_IDLE : fa_pkg::SRCH_MED;
         end
         default: begin
            state_in = fa_pkg::SRCH_IDLE;
         end
      endcase
   end

   always_comb begin
      stat.busy = (state_ff != fa_pkg::SRCH_IDLE);
      stat.done = (state_ff == fa_pkg::SRCH_CMP) && finish;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fa_pkg::SRCH_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Bounds carry their running products d*(f+err) and d*(f-err), so a
   // mediant needs only additions.
   always_ff @(posedge clock) begin
      unique case (state_ff)
         fa_pkg::SRCH_IDLE: begin
            if (ctl.start) begin
               ln_ff   <= '0;
               ld_ff   <= MW'(1);
               un_ff   <= MW'(1);
               ud_ff   <= MW'(1);
               pla_ff  <= PW'(a_in);
               pua_ff  <= PW'(a_in);
               qlb_ff  <= PW'(b_in);
               qub_ff  <= PW'(b_in);
               step_ff <= '0;
            end
         end
         fa_pkg::SRCH_MED: begin
            mn_ff <= ln_ff + un_ff;
            md_ff <= ld_ff + ud_ff;
            ma_ff <= pla_ff + pua_ff;
            mb_ff <= qlb_ff + qub_ff;
         end
         fa_pkg::SRCH_CMP: begin
            if (go_up) begin
               un_ff  <= mn_ff;
               ud_ff  <= md_ff;
               pua_ff <= ma_ff;
               qub_ff <= mb_ff;
            end else if (go_dn) begin
               ln_ff  <= mn_ff;
               ld_ff  <= md_ff;
               pla_ff <= ma_ff;
               qlb_ff <= mb_ff;
            end
            step_ff <= step_ff + MW'(1);
         end
         default: begin
         end
      endcase
   end

   assign num = mn_ff;
   assign den = md_ff;

endmodule

@@ src/fraction_approximator.sv @@
`timescale 1ns / 1ps
// Top level of the fraction approximator: setup, rounding, result build and output register.

// Turns a signed fixed-point value into numerator/denominator within a relative
// tolerance set by csr_wdata (units of 2^-16, zero means 66). One item at a
// time: after acceptance the states S_MUL, S_SAT and S_CLASS compute and
// saturate the absolute tolerance and classify the fraction; a whole-number
// result then goes through S_DONE to the output register. Otherwise the mediant
// search unit takes one add step and one compare step per Stern-Brocot step
// until a mediant lands inside the tolerance or the step limit is reached, and
// S_TMUL and S_TSUM then build the numerator. The output register lets the next
// item be accepted while a result waits on rsp_tready.
module fraction_approximator #(
   parameter int FRAC_BITS = 16,
   parameter int INT_BITS  = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_wen,
   input  logic [fa_pkg::REL_WIDTH-1:0]           csr_wdata,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // fields from bit 0: value
   input  logic [((INT_BITS+FRAC_BITS+7)/8)*8-1:0] req_tdata,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // fields from bit 0: numerator, denominator
   output logic [((fa_pkg::NUM_WIDTH+fa_pkg::DEN_WIDTH+7)/8)*8-1:0] rsp_tdata
);

   localparam int W      = INT_BITS + FRAC_BITS;
   localparam int E      = FRAC_BITS + fa_pkg::TOL_EXTRA;
   localparam int EW     = E + 1;
   localparam int AW     = E + 2;
   localparam int MW     = FRAC_BITS + 2;
   localparam int NW     = fa_pkg::NUM_WIDTH;
   localparam int DW     = fa_pkg::DEN_WIDTH;
   localparam int RW     = fa_pkg::REL_WIDTH;
   localparam int PRW    = RW + W;
   localparam int TW     = INT_BITS + MW;
   localparam int RSP_TW = ((NW + DW + 7) / 8) * 8;
   localparam int RSP_PAD = RSP_TW - NW - DW;
   localparam logic [PRW-1:0] ONE_P = PRW'(1) << E;
   localparam logic [EW-1:0]  ONE_E = EW'(1) << E;

   fa_pkg::fa_state_type     state_ff, state_in;
   fa_pkg::fa_srch_ctl_type  srch_ctl;
   fa_pkg::fa_srch_stat_type srch_stat;

   logic [RW-1:0]  rel_ff;
   logic           neg_ff;
   logic [W-1:0]   mag_ff;
   logic [PRW-1:0] prod_ff;
   logic [EW-1:0]  err_ff;
   logic [NW-1:0]  tot_ff;
   logic [DW-1:0]  den_ff;
   logic           rsp_valid_ff;
   logic [NW-1:0]  rsp_num_ff;
   logic [DW-1:0]  rsp_den_ff;

   logic [W-1:0]        value_w;
   logic [W-1:0]        mag_w;
   logic [RW-1:0]       rel_w;
   logic [INT_BITS-1:0] ip_w;
   logic [E-1:0]        f_w;
   logic [EW-1:0]       f_ext;
   logic                round_lo;
   logic                round_hi;
   logic [AW-1:0]       a_w;
   logic [AW-1:0]       b_w;
   logic [MW-1:0]       srch_num;
   logic [MW-1:0]       srch_den;
   logic [TW-1:0]       ipmd_w;
   logic                load_out;

   assign value_w  = req_tdata[W-1:0];
   assign mag_w    = value_w[W-1] ? (~value_w + W'(1)) : value_w;
   assign rel_w    = (rel_ff == '0) ? fa_pkg::TOL_DEFAULT : rel_ff;
   assign ip_w     = mag_ff[W-1:FRAC_BITS];
   assign f_w      = {mag_ff[FRAC_BITS-1:0], {fa_pkg::TOL_EXTRA{1'b0}}};
   assign f_ext    = {1'b0, f_w};
   assign round_lo = f_ext < err_ff;
   assign round_hi = (ONE_E - err_ff) < f_ext;
   assign a_w      = AW'(f_w) + AW'(err_ff);
   assign b_w      = AW'(f_w) - AW'(err_ff);
   assign ipmd_w   = TW'(ip_w) * TW'(srch_den);

   fa_mediant #(
      .FRAC_BITS (FRAC_BITS)
   ) u_mediant (
      .clock (clock),
      .reset (reset),
      .ctl   (srch_ctl),
      .a_in  (a_w),
      .b_in  (b_w),
      .stat  (srch_stat),
      .num   (srch_num),
      .den   (srch_den)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fa_pkg::S_IDLE: begin
            if (req_tvalid) begin
               state_in = fa_pkg::S_MUL;
            end
         end
         fa_pkg::S_MUL: begin
            state_in = fa_pkg::S_SAT;
         end
         fa_pkg::S_SAT: begin
            state_in = fa_pkg::S_CLASS;
         end
         fa_pkg::S_CLASS: begin
            state_in = (round_lo || round_hi) ? fa_pkg::S_DONE : fa_pkg::S_SEARCH;
         end
         fa_pkg::S_SEARCH: begin
            if (srch_stat.done) begin
               state_in = fa_pkg::S_TMUL;
            end
         end
         fa_pkg::S_TMUL: begin
            state_in = fa_pkg::S_TSUM;
         end
         fa_pkg::S_TSUM: begin
            state_in = fa_pkg::S_DONE;
         end
         fa_pkg::S_DONE: begin
            if (load_out) begin
               state_in = fa_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = fa_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready     = (state_ff == fa_pkg::S_IDLE);
      srch_ctl.start = (state_ff == fa_pkg::S_CLASS) && !round_lo && !round_hi;
      load_out       = (state_ff == fa_pkg::S_DONE) && (!rsp_valid_ff || rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fa_pkg::S_IDLE;
         rel_ff       <= fa_pkg::TOL_DEFAULT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wen) begin
            rel_ff <= csr_wdata;
         end
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         neg_ff <= value_w[W-1];
         mag_ff <= mag_w;
      end
      unique case (state_ff)
         fa_pkg::S_MUL: begin
            // zero input: the relative tolerance is used as an absolute one
            prod_ff <= (mag_ff == '0) ? (PRW'(rel_w) << FRAC_BITS)
                                      : (PRW'(rel_w) * PRW'(mag_ff));
         end
         fa_pkg::S_SAT: begin
            err_ff <= (prod_ff > ONE_P) ? ONE_E : prod_ff[EW-1:0];
         end
         fa_pkg::S_CLASS: begin
            den_ff <= DW'(1);
            if (round_lo) begin
               tot_ff <= NW'(ip_w);
            end else begin
               tot_ff <= NW'(ip_w) + NW'(1);
            end
         end
         fa_pkg::S_TMUL: begin
            tot_ff <= NW'(ipmd_w);
            den_ff <= DW'(srch_den);
         end
         fa_pkg::S_TSUM: begin
            tot_ff <= tot_ff + NW'(srch_num);
         end
         fa_pkg::S_DONE: begin
            if (load_out) begin
               rsp_num_ff <= neg_ff ? (NW'(0) - tot_ff) : tot_ff;
               rsp_den_ff <= den_ff;
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD{1'b0}}, rsp_den_ff, rsp_num_ff};

   a_idle_search_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == fa_pkg::S_IDLE) |-> !srch_stat.busy)
      else $error("mediant search busy while top level idle");

   a_search_done_owned: assert property (@(posedge clock) disable iff (reset)
      srch_stat.done |-> (state_ff == fa_pkg::S_SEARCH))
      else $error("mediant search finished outside search state");

   a_err_saturated: assert property (@(posedge clock) disable iff (reset)
      (state_ff == fa_pkg::S_CLASS) |-> (err_ff <= ONE_E))
      else $error("absolute tolerance above one");

endmodule
